>>> hw/rtl/pal_pkg.sv
package pal_pkg;

	localparam int POS_W   = 5;
	localparam int USED_W  = 6;
	localparam int NAME_W  = 64;
	localparam int COUNT_W = 32;

	typedef enum logic [2:0] {
		CMD_CLEAR  = 3'd0,
		CMD_INSERT = 3'd1,
		CMD_DELETE = 3'd2,
		CMD_FIND   = 3'd3,
		CMD_UPDATE = 3'd4,
		CMD_READ   = 3'd5
	} pal_cmd_t;

	typedef struct packed {
		logic [NAME_W-1:0]  name;
		logic [COUNT_W-1:0] count;
	} pal_entry_t;

	typedef struct packed {
		logic name_en;
		logic count_en;
	} pal_wr_t;

	typedef struct packed {
		logic               ok;
		logic               found;
		logic [POS_W-1:0]   position;
		logic [NAME_W-1:0]  name;
		logic [COUNT_W-1:0] count;
		logic [USED_W-1:0]  entries;
	} pal_result_t;

endpackage

>>> hw/rtl/pal_mem.sv
module pal_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic                clk,
	input  pal_pkg::pal_wr_t    wr,
	input  logic [AW-1:0]       wr_addr,
	input  pal_pkg::pal_entry_t wr_data,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output pal_pkg::pal_entry_t rd_data
);
	import pal_pkg::*;

	logic [NAME_W-1:0]  name_mem  [DEPTH];
	logic [COUNT_W-1:0] count_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.name_en) begin
			name_mem[wr_addr] <= wr_data.name;
		end
		if (wr.count_en) begin
			count_mem[wr_addr] <= wr_data.count;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data.name  <= name_mem[rd_addr];
			rd_data.count <= count_mem[rd_addr];
		end
	end

endmodule

>>> hw/rtl/pal_seq.sv
module pal_seq #(
	parameter int CAPACITY = 32,
	parameter int AW       = 5,
	parameter int CW       = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2:0]                  command,
	input  logic [pal_pkg::POS_W-1:0]   position,
	input  logic                        append,
	input  logic [pal_pkg::NAME_W-1:0]  name_key,
	input  logic [pal_pkg::COUNT_W-1:0] count_value,
	output logic                        res_valid,
	input  logic                        res_ready,
	output pal_pkg::pal_result_t        res,
	output pal_pkg::pal_wr_t            wr,
	output logic [AW-1:0]               wr_addr,
	output pal_pkg::pal_entry_t         wr_data,
	output logic                        rd_en,
	output logic [AW-1:0]               rd_addr,
	input  pal_pkg::pal_entry_t         rd_data
);
	import pal_pkg::*;

	// common compare width for positions and the entry count
	localparam int XW = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOVE,
		S_FIN,
		S_FIND,
		S_RDW,
		S_RESP
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      n_q;
	logic [CW-1:0]      mv_left_q;
	logic [CW-1:0]      scan_q;
	logic [AW-1:0]      src_q;
	logic [AW-1:0]      p_q;
	logic               ins_q;
	logic               pend_s1;
	logic [AW-1:0]      dst_s1;
	logic [NAME_W-1:0]  key_q;
	logic [COUNT_W-1:0] cnt_q;
	logic               ok_q;
	logic               found_q;
	logic [POS_W-1:0]   rpos_q;
	logic [NAME_W-1:0]  rname_q;
	logic [COUNT_W-1:0] rcount_q;

	pal_cmd_t      cmd;
	logic          accept;
	logic [XW-1:0] pos_x;
	logic [XW-1:0] n_x;
	logic [XW-1:0] ins_p;
	logic [XW-1:0] ins_left;
	logic [XW-1:0] ins_src;
	logic [XW-1:0] del_left;
	logic [XW-1:0] del_src;
	logic [XW-1:0] idx_x;
	logic          ins_ok;
	logic          pos_ok;
	logic          hit;

	assign cmd      = pal_cmd_t'(command);
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign pos_x    = XW'(position);
	assign n_x      = XW'(n_q);
	assign ins_p    = append ? n_x : pos_x;
	assign ins_ok   = (n_q < CW'(CAPACITY)) && (ins_p <= n_x);
	assign pos_ok   = pos_x < n_x;
	assign ins_left = n_x - ins_p;
	assign ins_src  = n_x - XW'(1);
	assign del_left = n_x - pos_x - XW'(1);
	assign del_src  = pos_x + XW'(1);
	assign idx_x    = XW'(dst_s1);
	assign hit      = pend_s1 && (rd_data.name == key_q);

	assign res_valid = (state_q == S_RESP);
	assign res       = '{ok: ok_q, found: found_q, position: rpos_q, name: rname_q,
		count: rcount_q, entries: USED_W'(n_q)};

	// memory port steering
	always_comb begin
		wr      = '0;
		wr_addr = dst_s1;
		wr_data = rd_data;
		rd_en   = 1'b0;
		rd_addr = src_q;
		case (state_q)
			S_IDLE: begin
				if (accept && cmd == CMD_UPDATE && pos_ok) begin
					wr.count_en = 1'b1;
					wr_addr     = pos_x[AW-1:0];
					wr_data     = '{name: name_key, count: count_value};
				end
				if (accept && cmd == CMD_READ && pos_ok) begin
					rd_en   = 1'b1;
					rd_addr = pos_x[AW-1:0];
				end
			end
			S_MOVE: begin
				// entry read last cycle lands one slot over
				if (pend_s1) begin
					wr = '{name_en: 1'b1, count_en: 1'b1};
				end
				if (mv_left_q != '0) begin
					rd_en = 1'b1;
				end
			end
			S_FIN: begin
				if (ins_q) begin
					wr      = '{name_en: 1'b1, count_en: 1'b1};
					wr_addr = p_q;
					wr_data = '{name: key_q, count: cnt_q};
				end
			end
			S_FIND: begin
				if (!hit && scan_q < n_q) begin
					rd_en   = 1'b1;
					rd_addr = scan_q[AW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			n_q       <= '0;
			mv_left_q <= '0;
			scan_q    <= '0;
			src_q     <= '0;
			p_q       <= '0;
			ins_q     <= 1'b0;
			pend_s1   <= 1'b0;
			dst_s1    <= '0;
			key_q     <= '0;
			cnt_q     <= '0;
			ok_q      <= 1'b0;
			found_q   <= 1'b0;
			rpos_q    <= '0;
			rname_q   <= '0;
			rcount_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						rpos_q   <= position;
						found_q  <= 1'b0;
						rname_q  <= '0;
						rcount_q <= '0;
						ok_q     <= 1'b0;
						key_q    <= name_key;
						cnt_q    <= count_value;
						pend_s1  <= 1'b0;
						state_q  <= S_RESP;
						case (cmd)
							CMD_CLEAR: begin
								n_q  <= '0;
								ok_q <= 1'b1;
							end
							CMD_INSERT: begin
								ins_q  <= 1'b1;
								rpos_q <= ins_p[POS_W-1:0];
								if (ins_ok) begin
									p_q       <= ins_p[AW-1:0];
									mv_left_q <= ins_left[CW-1:0];
									src_q     <= ins_src[AW-1:0];
									state_q   <= S_MOVE;
								end
							end
							CMD_DELETE: begin
								ins_q <= 1'b0;
								if (pos_ok) begin
									mv_left_q <= del_left[CW-1:0];
									src_q     <= del_src[AW-1:0];
									state_q   <= S_MOVE;
								end
							end
							CMD_FIND: begin
								ok_q    <= 1'b1;
								rpos_q  <= '0;
								scan_q  <= '0;
								state_q <= S_FIND;
							end
							CMD_UPDATE: begin
								ok_q <= pos_ok;
							end
							CMD_READ: begin
								if (pos_ok) begin
									ok_q    <= 1'b1;
									state_q <= S_RDW;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_MOVE: begin
					if (mv_left_q != '0) begin
						pend_s1   <= 1'b1;
						dst_s1    <= ins_q ? src_q + AW'(1) : src_q - AW'(1);
						src_q     <= ins_q ? src_q - AW'(1) : src_q + AW'(1);
						mv_left_q <= mv_left_q - CW'(1);
					end else begin
						pend_s1 <= 1'b0;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					n_q     <= ins_q ? n_q + CW'(1) : n_q - CW'(1);
					ok_q    <= 1'b1;
					state_q <= S_RESP;
				end
				S_FIND: begin
					if (hit) begin
						found_q  <= 1'b1;
						rpos_q   <= idx_x[POS_W-1:0];
						rname_q  <= rd_data.name;
						rcount_q <= rd_data.count;
						pend_s1  <= 1'b0;
						state_q  <= S_RESP;
					end else if (scan_q < n_q) begin
						pend_s1 <= 1'b1;
						dst_s1  <= scan_q[AW-1:0];
						scan_q  <= scan_q + CW'(1);
					end else begin
						pend_s1 <= 1'b0;
						state_q <= S_RESP;
					end
				end
				S_RDW: begin
					rname_q  <= rd_data.name;
					rcount_q <= rd_data.count;
					state_q  <= S_RESP;
				end
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/positional_array_list_core.sv
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_ready   | command, position, append, name_key, count_value
// out     | output    | out_valid / out_ready | ok, found, result_position, result_name,
//         |           |                       | result_count, entries_used
//
// One command at a time. Entries sit in a single-port-write, single-port-read memory,
// and shifts move one entry per cycle through it. Clear, update and refused
// commands go straight to the result; read waits on its memory read; insert and
// delete shift the tail of the list; find scans in order until a hit or the end.
// Reset empties the list at once; memory contents are not cleared.
// A finished result waits in the output register, so the next beat is taken meanwhile.
module positional_array_list_core #(
	parameter int CAPACITY = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2:0]                  command,
	input  logic [pal_pkg::POS_W-1:0]   position,
	input  logic                        append,
	input  logic [pal_pkg::NAME_W-1:0]  name_key,
	input  logic [pal_pkg::COUNT_W-1:0] count_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        ok,
	output logic                        found,
	output logic [pal_pkg::POS_W-1:0]   result_position,
	output logic [pal_pkg::NAME_W-1:0]  result_name,
	output logic [pal_pkg::COUNT_W-1:0] result_count,
	output logic [pal_pkg::USED_W-1:0]  entries_used
);
	import pal_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	pal_result_t res;
	pal_result_t out_q;
	logic        res_valid;
	logic        res_ready;
	logic        out_valid_q;
	pal_wr_t     wr;
	logic [AW-1:0] wr_addr;
	pal_entry_t  wr_data;
	logic        rd_en;
	logic [AW-1:0] rd_addr;
	pal_entry_t  rd_data;

	pal_seq #(
		.CAPACITY(CAPACITY),
		.AW(AW),
		.CW(CW)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.position(position),
		.append(append),
		.name_key(name_key),
		.count_value(count_value),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.wr(wr),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	pal_mem #(
		.DEPTH(CAPACITY),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.wr(wr),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (res_valid && res_ready) begin
				out_valid_q <= 1'b1;
				out_q       <= res;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign ok              = out_q.ok;
	assign found           = out_q.found;
	assign result_position = out_q.position;
	assign result_name     = out_q.name;
	assign result_count    = out_q.count;
	assign entries_used    = out_q.entries;

endmodule

>>> tb/positional_array_list_core_tb.sv
`timescale 1ns / 100ps

module positional_array_list_core_tb;
	import pal_pkg::*;

	localparam int LIST_DEPTH   = 32;
	localparam int RANDOM_ITEMS = 500;
	localparam int DRAIN_CYCLES = 64;
	localparam int CYCLE_LIMIT  = 400000;

	// codes the block leaves unused
	localparam logic [2:0] CMD_SPARE_LO = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;

	typedef struct {
		logic [2:0]         cmd;
		logic [POS_W-1:0]   pos;
		logic               app;
		logic [NAME_W-1:0]  key;
		logic [COUNT_W-1:0] cnt;
		bit                 hold;
	} list_cmd_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [2:0]           command = '0;
	logic [POS_W-1:0]     position = '0;
	logic                 append = 1'b0;
	logic [NAME_W-1:0]    name_key = '0;
	logic [COUNT_W-1:0]   count_value = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 ok;
	logic                 found;
	logic [POS_W-1:0]     result_position;
	logic [NAME_W-1:0]    result_name;
	logic [COUNT_W-1:0]   result_count;
	logic [USED_W-1:0]    entries_used;

	positional_array_list_core #(.CAPACITY(LIST_DEPTH)) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.command         (command),
		.position        (position),
		.append          (append),
		.name_key        (name_key),
		.count_value     (count_value),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.ok              (ok),
		.found           (found),
		.result_position (result_position),
		.result_name     (result_name),
		.result_count    (result_count),
		.entries_used    (entries_used)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	list_cmd_t   pending_cmds[$];
	pal_result_t expected_results[$];
	list_cmd_t   sent_cmd;

	// shadow list contents
	logic [NAME_W-1:0]  shadow_names[LIST_DEPTH];
	logic [COUNT_W-1:0] shadow_counts[LIST_DEPTH];
	int                 shadow_len = 0;

	int error_count   = 0;
	int checked_count = 0;
	int ok_count      = 0;
	int hit_count     = 0;
	int peak_len      = 0;
	int cmd_tally[8];
	int cycle_count   = 0;

	// generation-side view of the list length, used to bias positions and commands and to fill the list
	int gen_len = 0;
	bit next_hold = 1'b0;
	logic [NAME_W-1:0] key_pool[8];

	function automatic pal_result_t apply_list_cmd(input list_cmd_t c);
		pal_result_t r;
		int n;
		int p;
		int i;
		r = '0;
		n = shadow_len;
		p = int'(c.pos);
		r.position = c.pos;
		case (c.cmd)
			CMD_CLEAR: begin
				shadow_len = 0;
				r.ok = 1'b1;
			end
			CMD_INSERT: begin
				if (c.app)
					p = n;
				r.position = p[POS_W-1:0];
				if (n < LIST_DEPTH && p <= n) begin
					for (i = n; i > p; i--) begin
						shadow_names[i]  = shadow_names[i-1];
						shadow_counts[i] = shadow_counts[i-1];
					end
					shadow_names[p]  = c.key;
					shadow_counts[p] = c.cnt;
					shadow_len = n + 1;
					r.ok = 1'b1;
				end
			end
			CMD_DELETE: begin
				if (p < n) begin
					for (i = p; i + 1 < n; i++) begin
						shadow_names[i]  = shadow_names[i+1];
						shadow_counts[i] = shadow_counts[i+1];
					end
					shadow_len = n - 1;
					r.ok = 1'b1;
				end
			end
			CMD_FIND: begin
				r.ok = 1'b1;
				r.position = '0;
				for (i = 0; i < n; i++) begin
					if (!r.found && shadow_names[i] == c.key) begin
						r.found    = 1'b1;
						r.position = i[POS_W-1:0];
						r.name     = shadow_names[i];
						r.count    = shadow_counts[i];
					end
				end
			end
			CMD_UPDATE: begin
				if (p < n) begin
					shadow_counts[p] = c.cnt;
					r.ok = 1'b1;
				end
			end
			CMD_READ: begin
				if (p < n) begin
					r.name  = shadow_names[p];
					r.count = shadow_counts[p];
					r.ok    = 1'b1;
				end
			end
			default: ;
		endcase
		r.entries = shadow_len[USED_W-1:0];
		return r;
	endfunction

	task automatic queue_cmd(input logic [2:0] c, input int p, input logic a,
			input logic [NAME_W-1:0] k, input logic [COUNT_W-1:0] v);
		list_cmd_t it;
		int pe;
		it.cmd  = c;
		it.pos  = p[POS_W-1:0];
		it.app  = a;
		it.key  = k;
		it.cnt  = v;
		it.hold = next_hold;
		next_hold = 1'b0;
		pending_cmds.push_back(it);
		case (c)
			CMD_CLEAR: gen_len = 0;
			CMD_INSERT: begin
				pe = a ? gen_len : p;
				if (gen_len < LIST_DEPTH && pe <= gen_len)
					gen_len++;
			end
			CMD_DELETE: if (p < gen_len) gen_len--;
			default: ;
		endcase
	endtask

	function automatic logic [NAME_W-1:0] pick_key();
		if ($urandom_range(0, 9) < 7)
			return key_pool[3'($urandom_range(0, 7))];
		return {$urandom(), $urandom()};
	endfunction

	// mostly a position no higher than limit, sometimes anywhere
	function automatic int pick_pos(input int limit);
		if (limit > LIST_DEPTH - 1)
			limit = LIST_DEPTH - 1;
		if (limit < 0)
			limit = 0;
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(0, limit);
		return $urandom_range(0, LIST_DEPTH - 1);
	endfunction

	task automatic check_field(input string what, input logic [63:0] exp_v,
			input logic [63:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch, expected %h actual %h", $realtime, what, exp_v, got_v);
			error_count++;
		end
	endtask

	// driver: bursts of beats separated by random gaps
	int burst_left = 4;
	int gap_left   = 0;

	always @(posedge clk) begin : drive_blk
		list_cmd_t   nxt;
		pal_result_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				r = apply_list_cmd(sent_cmd);
				expected_results.push_back(r);
				cmd_tally[sent_cmd.cmd]++;
				if (r.ok)
					ok_count++;
				if (r.found)
					hit_count++;
				if (shadow_len > peak_len)
					peak_len = shadow_len;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_cmds.size() > 0 &&
						(!pending_cmds[0].hold || expected_results.size() == 0)) begin
					nxt = pending_cmds.pop_front();
					sent_cmd    <= nxt;
					command     <= nxt.cmd;
					position    <= nxt.pos;
					append      <= nxt.app;
					name_key    <= nxt.key;
					count_value <= nxt.cnt;
					in_valid    <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 20);
						case ($urandom_range(0, 3))
							0: gap_left = 0;
							1: gap_left = $urandom_range(1, 3);
							2: gap_left = $urandom_range(1, 10);
							default: gap_left = $urandom_range(10, 30);
						endcase
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compares each result beat; ready follows a 16-bit pattern
	logic [15:0] ready_pattern = 16'hffff;
	int          pattern_idx   = 0;

	always @(posedge clk) begin : monitor_blk
		pal_result_t exp_r;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result beat with nothing expected, %s ok=%b pos=%0d",
						$realtime, "expected none actual", ok, result_position);
					error_count++;
				end else begin
					exp_r = expected_results.pop_front();
					checked_count++;
					check_field("ok", 64'(exp_r.ok), 64'(ok));
					check_field("found", 64'(exp_r.found), 64'(found));
					check_field("result_position", 64'(exp_r.position), 64'(result_position));
					check_field("result_name", exp_r.name, result_name);
					check_field("result_count", 64'(exp_r.count), 64'(result_count));
					check_field("entries_used", 64'(exp_r.entries), 64'(entries_used));
				end
			end
			if (pattern_idx == 0) begin
				case ($urandom_range(0, 3))
					0: ready_pattern = 16'hffff;
					1: ready_pattern = 16'($urandom());
					2: ready_pattern = 16'($urandom() | $urandom());
					default: ready_pattern = 16'($urandom() & $urandom());
				endcase
			end
			out_ready <= ready_pattern[pattern_idx];
			pattern_idx = (pattern_idx + 1) % 16;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $realtime, cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin : stimulus
		int i;
		int sent;
		int pick;
		int j;
		logic [2:0] c;
		for (i = 0; i < 8; i++)
			cmd_tally[i] = 0;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (i = 2; i < 8; i++)
			key_pool[i] = {$urandom(), $urandom()};

		// directed: empty list, edges of positions, duplicate names, spare codes
		queue_cmd(CMD_FIND, 0, 1'b0, '0, '0);
		queue_cmd(CMD_READ, 0, 1'b0, '0, '0);
		queue_cmd(CMD_DELETE, 0, 1'b0, '0, '0);
		queue_cmd(CMD_UPDATE, 0, 1'b0, '0, '1);
		queue_cmd(CMD_INSERT, 1, 1'b0, '1, '1);
		queue_cmd(CMD_INSERT, 31, 1'b1, '1, '1);
		queue_cmd(CMD_INSERT, 0, 1'b0, '0, '0);
		queue_cmd(CMD_INSERT, 2, 1'b0, key_pool[2], 32'h5a5a_a5a5);
		queue_cmd(CMD_INSERT, 1, 1'b0, '1, 32'd5);
		queue_cmd(CMD_FIND, 31, 1'b1, '1, '1);
		queue_cmd(CMD_FIND, 7, 1'b0, 64'h0123_4567_89ab_cdef, '0);
		queue_cmd(CMD_READ, 3, 1'b0, '1, '1);
		queue_cmd(CMD_READ, 4, 1'b0, '0, '0);
		queue_cmd(CMD_UPDATE, 2, 1'b0, '0, '0);
		queue_cmd(CMD_UPDATE, 31, 1'b1, '1, '1);
		queue_cmd(CMD_DELETE, 1, 1'b0, '0, '0);
		queue_cmd(CMD_READ, 1, 1'b0, '0, '0);
		queue_cmd(CMD_SPARE_LO, 17, 1'b0, '1, '1);
		queue_cmd(CMD_SPARE_HI, 31, 1'b1, '1, '1);
		queue_cmd(CMD_DELETE, 5, 1'b0, '0, '0);
		queue_cmd(CMD_CLEAR, 31, 1'b1, '1, '1);
		queue_cmd(CMD_FIND, 0, 1'b0, '0, '0);
		queue_cmd(CMD_INSERT, 0, 1'b0, key_pool[3], 32'h8000_0001);

		next_hold = 1'b1;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				// fill to capacity, then push against the full list
				if ($urandom_range(0, 1))
					queue_cmd(CMD_CLEAR, $urandom_range(0, 31), 1'($urandom_range(0, 1)),
						{$urandom(), $urandom()}, $urandom());
				while (gen_len < LIST_DEPTH) begin
					queue_cmd(CMD_INSERT, $urandom_range(0, 31), 1'b1, pick_key(), $urandom());
					sent++;
				end
				for (j = 0; j < 3; j++) begin
					queue_cmd(CMD_INSERT, pick_pos(LIST_DEPTH), 1'($urandom_range(0, 1)),
						pick_key(), $urandom());
					queue_cmd(CMD_READ, LIST_DEPTH - 1 - j, 1'b0, '0, '0);
					queue_cmd(CMD_FIND, 0, 1'b0, pick_key(), '0);
					sent += 3;
				end
				queue_cmd(CMD_DELETE, LIST_DEPTH - 1, 1'b0, '0, '0);
				queue_cmd(CMD_INSERT, 0, 1'b0, pick_key(), $urandom());
				sent += 2;
			end else if (pick < 9) begin
				next_hold = 1'b1;
			end else begin
				pick = $urandom_range(0, 99);
				if (gen_len > 22)
					pick = (pick < 40) ? 40 : pick;
				if (pick < 35)
					c = CMD_INSERT;
				else if (pick < 55)
					c = CMD_DELETE;
				else if (pick < 70)
					c = CMD_FIND;
				else if (pick < 81)
					c = CMD_UPDATE;
				else if (pick < 94)
					c = CMD_READ;
				else if (pick < 97)
					c = CMD_CLEAR;
				else
					c = $urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI;
				case (c)
					CMD_INSERT:
						queue_cmd(c, pick_pos(gen_len), $urandom_range(0, 3) == 0,
							pick_key(), $urandom());
					CMD_FIND:
						queue_cmd(c, $urandom_range(0, 31), 1'($urandom_range(0, 1)),
							pick_key(), $urandom());
					default:
						queue_cmd(c, pick_pos(gen_len - 1), 1'($urandom_range(0, 1)),
							{$urandom(), $urandom()}, $urandom());
				endcase
				sent++;
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			$display("%0t: results still outstanding, expected 0 actual %0d",
				$realtime, expected_results.size());
			error_count++;
		end

		$display("Covered %0d results: clear %0d, insert %0d, delete %0d, find %0d,",
			checked_count, cmd_tally[CMD_CLEAR], cmd_tally[CMD_INSERT],
			cmd_tally[CMD_DELETE], cmd_tally[CMD_FIND]);
		$display("  update %0d, read %0d, spare %0d; %0d succeeded, %0d finds hit, peak %0d of %0d",
			cmd_tally[CMD_UPDATE], cmd_tally[CMD_READ],
			cmd_tally[CMD_SPARE_LO] + cmd_tally[CMD_SPARE_HI],
			ok_count, hit_count, peak_len, LIST_DEPTH);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/pal_pkg.sv
hw/rtl/pal_mem.sv
hw/rtl/pal_seq.sv
hw/rtl/positional_array_list_core.sv
tb/positional_array_list_core_tb.sv
